### src/chgw_pkg.sv
// ----------------------------------------------------------------------------
// chgw_pkg
// Shared types and constants for the gift-wrap convex hull block.
// ----------------------------------------------------------------------------
package chgw_pkg;

    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 8;
    localparam int IN_W     = 3 * COORD_W;
    localparam int OUT_W    = INDEX_W + 3 * COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // input request present in load state
        logic sweep_init;  // restart the point sweep at index zero
        logic rd;          // issue store read for the current sweep index
        logic lat;         // capture store read data and differences
        logic mul;         // register cross-product terms
        logic upd;         // decide on the candidate and step the sweep
        logic wrap_mode;   // 0: start point search, 1: wrapping search
        logic take_start;  // start point found, becomes current vertex
        logic emit_load;   // load the output register with the current vertex
        logic advance;     // move to the next hull vertex
        logic clear_set;   // point set done, clear count and drop flag
    } chgw_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic j_last;      // sweep index is the last stored point
        logic out_last;    // vertex in the output register ends the hull
    } chgw_status_t;

endpackage

### src/chgw_ram.sv
// ----------------------------------------------------------------------------
// chgw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/chgw_ctrl.sv
// ----------------------------------------------------------------------------
// chgw_ctrl
// Controller: load, start point sweep, wrapping sweeps and vertex output.
// ----------------------------------------------------------------------------
module chgw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    input  logic                  m_tready,
    input  chgw_pkg::chgw_status_t status,
    output chgw_pkg::chgw_cmd_t    cmd,
    output logic                  s_tready,
    output logic                  m_tvalid
);

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_RD   = 6'b000010,
        ST_LAT  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_EMIT = 6'b100000
    } chgw_state_t;

    chgw_state_t state_reg;
    chgw_state_t state_next;
    logic        mode_reg;
    logic        mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cmd           = '0;
        cmd.wrap_mode = mode_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    cmd.sweep_init = 1'b1;
                    mode_next      = 1'b0;
                    state_next     = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LAT;
            end
            ST_LAT:
            begin
                cmd.lat    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (!status.j_last)
                begin
                    state_next = ST_RD;
                end
                else if (!mode_reg)
                begin
                    cmd.take_start = 1'b1;
                    cmd.sweep_init = 1'b1;
                    mode_next      = 1'b1;
                    state_next     = ST_RD;
                end
                else
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (status.out_last)
                    begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        cmd.advance    = 1'b1;
                        cmd.sweep_init = 1'b1;
                        state_next     = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);

endmodule

### src/chgw_dp.sv
// ----------------------------------------------------------------------------
// chgw_dp
// Datapath: point stores, sweep counter, cross-product unit, vertex registers.
// ----------------------------------------------------------------------------
module chgw_dp #(
    parameter int POINT_CAPACITY = 256,
    parameter int HULL_LIMIT     = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  chgw_pkg::chgw_cmd_t          cmd,
    input  logic [chgw_pkg::IN_W-1:0]    s_tdata,
    output chgw_pkg::chgw_status_t       status,
    output logic [chgw_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    localparam int AW = $clog2(POINT_CAPACITY);
    localparam int CW = $clog2(POINT_CAPACITY + 1);
    localparam int NW = $clog2(HULL_LIMIT + 1);
    localparam int CO = chgw_pkg::COORD_W;
    localparam int XZ = 2 * chgw_pkg::COORD_W;

    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_plus;
    logic [NW-1:0] nh_reg;
    logic [NW-1:0] nh_plus;

    logic [XZ-1:0] xz_rdata;
    logic [CO-1:0] h_rdata;
    logic          store_we;

    logic signed [CO-1:0] cand_x_reg, cand_z_reg;
    logic        [CO-1:0] cand_h_reg;
    logic signed [CO-1:0] best_x_reg, best_z_reg;
    logic        [CO-1:0] best_h_reg;
    logic        [AW-1:0] best_idx_reg;
    logic signed [CO-1:0] cur_x_reg, cur_z_reg;
    logic        [CO-1:0] cur_h_reg;
    logic        [AW-1:0] cur_idx_reg;
    logic        [AW-1:0] start_idx_reg;

    logic signed [chgw_pkg::DIFF_W-1:0] u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [chgw_pkg::PROD_W-1:0] p1_reg, p2_reg;

    logic signed [CO-1:0] rd_x, rd_z;
    logic                 lower_left;
    logic                 take;
    logic signed [CO-1:0] nb_x, nb_z;
    logic        [CO-1:0] nb_h;
    logic        [AW-1:0] nb_idx;
    logic                 vertex_last;
    logic        [AW+7:0] idx_wide;

    logic [chgw_pkg::INDEX_W-1:0] out_idx_reg;
    logic [CO-1:0]                out_x_reg, out_h_reg, out_z_reg;
    logic                         out_last_reg, out_ovf_reg;

    assign store_we = cmd.load && (count_reg != CW'(POINT_CAPACITY));

    // x in the upper half, z in the lower half
    chgw_ram #(.WIDTH(XZ), .DEPTH(POINT_CAPACITY)) u_xz_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({s_tdata[CO-1:0], s_tdata[3*CO-1:2*CO]}),
        .re    (cmd.rd),
        .raddr (j_reg[AW-1:0]),
        .rdata (xz_rdata)
    );

    chgw_ram #(.WIDTH(CO), .DEPTH(POINT_CAPACITY)) u_h_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[2*CO-1:CO]),
        .re    (cmd.rd),
        .raddr (j_reg[AW-1:0]),
        .rdata (h_rdata)
    );

    assign j_plus  = j_reg + CW'(1);
    assign nh_plus = nh_reg + NW'(1);
    assign rd_x    = $signed(xz_rdata[XZ-1:CO]);
    assign rd_z    = $signed(xz_rdata[CO-1:0]);

    assign lower_left = (cand_x_reg < best_x_reg) ||
                        ((cand_x_reg == best_x_reg) && (cand_z_reg < best_z_reg));

    // first point always seeds the best; wrapping also replaces a best equal
    // to the current vertex or one with the candidate strictly on the turn side
    always_comb
    begin
        if (j_reg == '0)
        begin
            take = 1'b1;
        end
        else if (!cmd.wrap_mode)
        begin
            take = lower_left;
        end
        else
        begin
            take = (cur_idx_reg == best_idx_reg) || (p1_reg < p2_reg);
        end
    end

    assign nb_x   = take ? cand_x_reg : best_x_reg;
    assign nb_z   = take ? cand_z_reg : best_z_reg;
    assign nb_h   = take ? cand_h_reg : best_h_reg;
    assign nb_idx = take ? j_reg[AW-1:0] : best_idx_reg;

    assign vertex_last = (nb_idx == start_idx_reg) || (nh_plus == NW'(HULL_LIMIT));
    assign idx_wide    = {8'd0, cur_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            j_reg       <= '0;
            nh_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_set)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (store_we)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end

            if (cmd.sweep_init)
            begin
                j_reg <= '0;
            end
            else if (cmd.upd)
            begin
                j_reg <= j_plus;
            end

            if (cmd.take_start)
            begin
                nh_reg <= '0;
            end
            else if (cmd.advance)
            begin
                nh_reg <= nh_plus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lat)
        begin
            cand_x_reg <= rd_x;
            cand_z_reg <= rd_z;
            cand_h_reg <= h_rdata;
            u2_reg     <= $signed({rd_x[CO-1], rd_x}) - $signed({cur_x_reg[CO-1], cur_x_reg});
            v2_reg     <= $signed({rd_z[CO-1], rd_z}) - $signed({cur_z_reg[CO-1], cur_z_reg});
            u1_reg     <= $signed({best_x_reg[CO-1], best_x_reg})
                          - $signed({cur_x_reg[CO-1], cur_x_reg});
            v1_reg     <= $signed({best_z_reg[CO-1], best_z_reg})
                          - $signed({cur_z_reg[CO-1], cur_z_reg});
        end

        if (cmd.mul)
        begin
            p1_reg <= u1_reg * v2_reg;
            p2_reg <= v1_reg * u2_reg;
        end

        if (cmd.upd)
        begin
            best_x_reg   <= nb_x;
            best_z_reg   <= nb_z;
            best_h_reg   <= nb_h;
            best_idx_reg <= nb_idx;
        end

        if (cmd.take_start)
        begin
            cur_x_reg     <= nb_x;
            cur_z_reg     <= nb_z;
            cur_h_reg     <= nb_h;
            cur_idx_reg   <= nb_idx;
            start_idx_reg <= nb_idx;
        end
        else if (cmd.advance)
        begin
            cur_x_reg   <= best_x_reg;
            cur_z_reg   <= best_z_reg;
            cur_h_reg   <= best_h_reg;
            cur_idx_reg <= best_idx_reg;
        end

        if (cmd.emit_load)
        begin
            out_idx_reg  <= idx_wide[7:0];
            out_x_reg    <= cur_x_reg;
            out_h_reg    <= cur_h_reg;
            out_z_reg    <= cur_z_reg;
            out_last_reg <= vertex_last;
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign status.j_last   = (j_plus == count_reg);
    assign status.out_last = out_last_reg;

    assign m_tdata = {out_z_reg, out_h_reg, out_x_reg, out_idx_reg};
    assign m_tlast = out_last_reg;
    assign m_tuser = out_ovf_reg;

endmodule

### src/convex_hull_gift_wrap.sv
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// 2D convex hull on the x-z plane by gift wrapping over a stored point set.
// ----------------------------------------------------------------------------
// load: one point request per cycle, stored in load order
// after the last point: a start search sweep, then per hull vertex a wrapping
// sweep and an output handshake; each sweep does read, difference, multiply
// and decide per point; no input is taken during the hull walk; point stores
// are not cleared at reset, only the controller, point count, drop flag,
// sweep index and hull vertex count are
module convex_hull_gift_wrap #(
    parameter int POINT_CAPACITY = 256,
    parameter int HULL_LIMIT     = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [chgw_pkg::IN_W-1:0]  s_tdata,   // point_x, point_height, point_z
    input  logic                       s_tlast,   // last_point
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [chgw_pkg::OUT_W-1:0] m_tdata,   // hull_index, hull_x, hull_height, hull_z
    output logic                       m_tlast,   // last_vertex
    output logic                       m_tuser    // overflow
);

    chgw_pkg::chgw_cmd_t    cmd;
    chgw_pkg::chgw_status_t status;

    chgw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    chgw_dp #(
        .POINT_CAPACITY (POINT_CAPACITY),
        .HULL_LIMIT     (HULL_LIMIT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

### src/chgw_check.sv
// ----------------------------------------------------------------------------
// chgw_check
// Port-level checks for the gift-wrap convex hull block.
// ----------------------------------------------------------------------------
module chgw_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [chgw_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);

    // loading and vertex output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a vertex is offered");

    // the last point request closes the input for the hull walk
    a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after the last point");

    // final vertex ends the output burst
    a_end_of_hull: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("output continues after the final vertex");

    // stalled vertex holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled vertex changed");

endmodule

bind convex_hull_gift_wrap chgw_check u_chgw_check (.*);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for convex_hull_gift_wrap. Point sets are streamed in on the
// slave side, and a scoreboard computes the expected hull of each set and
// compares it field by field with every vertex accepted on the master side.
// Both sides idle at random, except during periodic calm windows.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W        = chgw_pkg::COORD_W;
    localparam int INDEX_W        = chgw_pkg::INDEX_W;
    localparam int IN_W           = chgw_pkg::IN_W;
    localparam int OUT_W          = chgw_pkg::OUT_W;
    localparam int POINT_CAPACITY = 256;
    localparam int HULL_LIMIT     = 32;
    localparam int RANDOM_ITEMS   = 200;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [INDEX_W-1:0]        index_t;

    localparam coord_t COORD_MIN = 24'sh800000;
    localparam coord_t COORD_MAX = 24'sh7FFFFF;

    typedef struct packed {
        coord_t x;
        coord_t height;
        coord_t z;
        logic   last_point;
    } hull_point_t;

    typedef struct packed {
        index_t             index;
        coord_t             x;
        coord_t             height;
        coord_t             z;
        logic               last_vertex;
        logic               overflow;
    } hull_vertex_t;

    class hull_scoreboard;
        int           mismatch_count;
        int           point_total;
        bit           points_dropped;
        coord_t       xs[POINT_CAPACITY];
        coord_t       heights[POINT_CAPACITY];
        coord_t       zs[POINT_CAPACITY];
        hull_vertex_t expected_vertices[$];

        function void note_point(hull_point_t p);
            int           start;
            int           cur;
            int           best;
            int           j;
            longint       u1;
            longint       v1;
            longint       u2;
            longint       v2;
            int           walk[$];
            hull_vertex_t v;
            if (point_total < POINT_CAPACITY)
            begin
                xs[point_total]      = p.x;
                heights[point_total] = p.height;
                zs[point_total]      = p.z;
                point_total++;
            end
            else
            begin
                points_dropped = 1'b1;
            end
            if (!p.last_point)
                return;
            if (point_total > 0)
            begin
                // lowest x first, then lowest z, earliest wins a full tie
                start = 0;
                for (j = 1; j < point_total; j++)
                    if (xs[j] < xs[start] || (xs[j] == xs[start] && zs[j] < zs[start]))
                        start = j;
                cur = start;
                do
                begin
                    walk.push_back(cur);
                    best = 0;
                    for (j = 1; j < point_total; j++)
                    begin
                        u1 = longint'(xs[best]) - longint'(xs[cur]);
                        v1 = longint'(zs[best]) - longint'(zs[cur]);
                        u2 = longint'(xs[j]) - longint'(xs[cur]);
                        v2 = longint'(zs[j]) - longint'(zs[cur]);
                        // strict turn test, collinear candidates replace only a best equal to cur
                        if (cur == best || u1 * v2 - v1 * u2 < 0)
                            best = j;
                    end
                    cur = best;
                end
                while (cur != start && walk.size() < HULL_LIMIT);
                foreach (walk[k])
                begin
                    v.index       = index_t'(walk[k]);
                    v.x           = xs[walk[k]];
                    v.height      = heights[walk[k]];
                    v.z           = zs[walk[k]];
                    v.last_vertex = (k == walk.size() - 1);
                    v.overflow    = points_dropped;
                    expected_vertices.push_back(v);
                end
            end
            point_total    = 0;
            points_dropped = 1'b0;
        endfunction

        function void report(string what, longint want_val, longint got_val);
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want_val, got_val);
        endfunction

        function void check_vertex(hull_vertex_t got);
            hull_vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: vertex expected none actual index %0d", $time, got.index);
                return;
            end
            want = expected_vertices.pop_front();
            if (got.index != want.index)
                report("hull_index", want.index, got.index);
            if (got.x != want.x)
                report("hull_x", want.x, got.x);
            if (got.height != want.height)
                report("hull_height", want.height, got.height);
            if (got.z != want.z)
                report("hull_z", want.z, got.z);
            if (got.last_vertex != want.last_vertex)
                report("last_vertex", want.last_vertex, got.last_vertex);
            if (got.overflow != want.overflow)
                report("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // point_x, point_height, point_z
    logic              s_tlast;    // last_point
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;    // hull_index, hull_x, hull_height, hull_z
    logic              m_tlast;    // last_vertex
    logic              m_tuser;    // overflow

    int                cycle_count = 0;
    logic              calm;
    hull_scoreboard    board;

    convex_hull_gift_wrap #(
        .POINT_CAPACITY (POINT_CAPACITY),
        .HULL_LIMIT     (HULL_LIMIT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // windows with no idling on either side
    assign calm = (cycle_count % 16384) < 2048;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = calm || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        hull_vertex_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.index       = m_tdata[INDEX_W-1:0];
                got.x           = m_tdata[INDEX_W +: COORD_W];
                got.height      = m_tdata[INDEX_W + COORD_W +: COORD_W];
                got.z           = m_tdata[INDEX_W + 2 * COORD_W +: COORD_W];
                got.last_vertex = m_tlast;
                got.overflow    = m_tuser;
                board.check_vertex(got);
            end
        end
    end

    task automatic send_point(coord_t x, coord_t height, coord_t z, logic last_point);
        hull_point_t p;
        p.x          = x;
        p.height     = height;
        p.z          = z;
        p.last_point = last_point;
        while (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {z, height, x};
        s_tlast  = last_point;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_point(p);
        @(negedge clk);
    endtask

    // 0: full range, 1: tiny grid with duplicates and collinear runs,
    // 2: extremes, 3: moderate range
    function automatic coord_t pick_coord(int style);
        case (style)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(8)) - 4);
            2:
            begin
                case ($urandom_range(3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
            end
            default: return coord_t'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic send_random_set(int n, int style);
        int st;
        for (int i = 0; i < n; i++)
        begin
            st = (style == 4) ? $urandom_range(3) : style;
            send_point(pick_coord(st), coord_t'($urandom), pick_coord(st), i == n - 1);
        end
    endtask

    // strictly convex points on a parabola, sent from a random rotation
    task automatic send_curve_set(int n);
        int rot;
        int step;
        int ox;
        int oz;
        int k;
        rot  = $urandom_range(n - 1);
        step = $urandom_range(1, 50);
        ox   = int'($urandom_range(200000)) - 100000;
        oz   = int'($urandom_range(200000)) - 100000;
        for (int i = 0; i < n; i++)
        begin
            k = (i + rot) % n;
            send_point(coord_t'(ox + k * step), coord_t'($urandom),
                       coord_t'(oz + (k - n / 2) * (k - n / 2) * step), i == n - 1);
        end
    endtask

    initial
    begin
        int sent;
        int n;
        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single point set
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        // square at the extreme corners, collinear points on an edge and inside
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_point(coord_t'(0), coord_t'(0), COORD_MIN, 1'b0);
        send_point(COORD_MAX, coord_t'(-1), COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN, coord_t'(1), COORD_MAX, 1'b0);
        send_point(coord_t'(0), coord_t'(7), coord_t'(0), 1'b1);
        // two identical points
        send_point(coord_t'(5), coord_t'(1), coord_t'(5), 1'b0);
        send_point(coord_t'(5), coord_t'(2), coord_t'(5), 1'b1);
        // tie on x, start point decided by z
        send_point(coord_t'(0), coord_t'(3), coord_t'(3), 1'b0);
        send_point(coord_t'(0), coord_t'(4), coord_t'(-3), 1'b0);
        send_point(coord_t'(4), coord_t'(5), coord_t'(0), 1'b1);
        // all points on one line
        send_point(coord_t'(1), coord_t'(0), coord_t'(1), 1'b0);
        send_point(coord_t'(2), coord_t'(0), coord_t'(2), 1'b0);
        send_point(coord_t'(3), coord_t'(0), coord_t'(3), 1'b0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        // triangle loaded clockwise
        send_point(COORD_MIN, COORD_MAX, coord_t'(0), 1'b0);
        send_point(coord_t'(100), COORD_MIN, COORD_MAX, 1'b0);
        send_point(coord_t'(200), coord_t'(0), COORD_MIN, 1'b1);

        // exactly full store, start point at the highest index
        for (int i = 0; i < POINT_CAPACITY - 1; i++)
            send_point(pick_coord(0), coord_t'($urandom), pick_coord(0), 1'b0);
        send_point(COORD_MIN, coord_t'($urandom), COORD_MIN, 1'b1);
        // overflowing set, the flagged request itself is dropped
        send_random_set(POINT_CAPACITY + 3, 4);
        // hull longer than the vertex limit
        send_curve_set(40);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(3, 45);
                send_curve_set(n);
            end
            else
            begin
                n = $urandom_range(1, 16);
                send_random_set(n, $urandom_range(4));
            end
            sent += n;
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (board.expected_vertices.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
src/chgw_pkg.sv
src/chgw_ram.sv
src/chgw_ctrl.sv
src/chgw_dp.sv
src/convex_hull_gift_wrap.sv
src/chgw_check.sv
verif/tb.sv
